/* design/adi_pkg.sv */
package adi_pkg;
  localparam int unsigned CPU_CLOCK_HZ_DEF = 93750000;
  localparam int unsigned DAC_CLOCK_HZ_DEF = 48681812;
  localparam int unsigned DEFAULT_RATE_DEF = 44100;
  localparam int unsigned RATE_MIN = 4000;
  localparam int unsigned RATE_MAX = 96000;
  localparam logic [5:0] MAX_FETCH = 6'd39;

  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [4:0] REG_ADDR   = 5'h00;
  localparam logic [4:0] REG_LEN    = 5'h04;
  localparam logic [4:0] REG_CTRL   = 5'h08;
  localparam logic [4:0] REG_STATUS = 5'h0C;
  localparam logic [4:0] REG_DRATE  = 5'h10;
  localparam logic [4:0] REG_BRATE  = 5'h14;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV1, ST_DIV2, ST_TICK, ST_FETCH, ST_IRQ, ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;
endpackage

/* design/adi_div.sv */
module adi_div import adi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        done,
  output logic [31:0] quotient
);
  logic [31:0] rem, quo, dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
      cnt <= 6'd0;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
      cnt <= cnt + 6'd1;
      if (cnt == 6'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

/* design/audio_dma_interface_with_rate_pacing.sv */
// Audio DMA register block. One request at a time: reads, writes, idle ticks
// and unused commands answer from the idle state; a DAC rate write or a job
// start then runs serial divisions to set the frame period (two divisions,
// one when the DAC rate register is zero); an active tick fetches frames
// (at most 39) and raises the interrupt when the job ends, and a queued job
// starting after it runs the period division again.
module audio_dma_interface_with_rate_pacing import adi_pkg::*; #(
  parameter int unsigned CPU_CLOCK_HZ = CPU_CLOCK_HZ_DEF,
  parameter int unsigned DAC_CLOCK_HZ = DAC_CLOCK_HZ_DEF,
  parameter int unsigned DEFAULT_RATE = DEFAULT_RATE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [4:0]  reg_offset,
  input  logic [31:0] write_data,
  input  logic [14:0] tick_cycles,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        fetch_valid,
  output logic [31:0] fetch_address,
  output logic        irq_raise,
  output logic        irq_clear,
  output logic        job_dropped,
  output logic        last
);
  localparam logic [13:0] DRATE_RST = 14'((DAC_CLOCK_HZ / DEFAULT_RATE - 1) & 16'h3FFF);
  localparam int unsigned R_DIV = DAC_CLOCK_HZ / ({18'd0, DRATE_RST} + 32'd1);
  localparam int unsigned R0 = (DRATE_RST == 14'd0) ? DEFAULT_RATE :
                               (R_DIV < RATE_MIN) ? RATE_MIN :
                               (R_DIV > RATE_MAX) ? RATE_MAX : R_DIV;
  localparam int unsigned P0 = CPU_CLOCK_HZ / R0;
  localparam logic [15:0] PERIOD_RST = (P0 % 65536 == 0) ? 16'd1 : 16'(P0 % 65536);

  state_t state, state_next;
  logic [23:0] dram_address_reg, queued_address;
  logic [17:0] xfer_len, queued_length, bytes_left;
  logic        control_bit, active_flag, queued_flag;
  logic [13:0] dac_rate_reg;
  logic [3:0]  bit_rate_reg;
  logic [31:0] fetch_cursor, cycle_accumulator;
  logic [15:0] frame_period;
  logic [14:0] cyc;
  logic [5:0]  fetched;
  logic        pend_start;

  div_req_t    dreq;
  logic        ddone;
  logic [31:0] dq;

  adi_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quotient(dq));

  logic [32:0] acc_sum;
  logic [31:0] rate_c;
  logic        can_fetch;
  logic [31:0] acc_dec;
  logic [17:0] left_dec;
  logic        fetch_more;
  assign acc_sum = {1'b0, cycle_accumulator} + {18'd0, cyc};
  assign rate_c = (dq < RATE_MIN) ? RATE_MIN : (dq > RATE_MAX) ? RATE_MAX : dq;
  assign can_fetch = (fetched < MAX_FETCH) && (cycle_accumulator >= {16'd0, frame_period})
                     && (bytes_left >= 18'd4);
  assign acc_dec = cycle_accumulator - {16'd0, frame_period};
  assign left_dec = bytes_left - 18'd4;
  assign fetch_more = ((fetched + 6'd1) < MAX_FETCH) && (acc_dec >= {16'd0, frame_period});
  assign in_ready = (state == ST_IDLE) && !out_valid && !pend_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dreq = '0;
    unique case (state)
      ST_IDLE: if (pend_start && !out_valid) begin
        if (dac_rate_reg == 14'd0) begin
          state_next = ST_DIV2;
          dreq = '{1'b1, CPU_CLOCK_HZ, DEFAULT_RATE};
        end else begin
          state_next = ST_DIV1;
          dreq = '{1'b1, DAC_CLOCK_HZ, {18'd0, dac_rate_reg} + 32'd1};
        end
      end else if (in_valid && in_ready && command == CMD_TICK && active_flag
                   && bytes_left != 18'd0) begin
        state_next = ST_TICK;
      end
      ST_DIV1: if (ddone) begin
        state_next = ST_DIV2;
        dreq = '{1'b1, CPU_CLOCK_HZ, rate_c};
      end
      ST_DIV2: if (ddone) state_next = ST_IDLE;
      ST_TICK: state_next = ST_FETCH;
      ST_FETCH: if (!out_valid || out_ready) begin
        if (!can_fetch) state_next = (bytes_left < 18'd4) ? ST_IRQ : ST_OUT;
      end
      ST_IRQ: if (!out_valid || out_ready) state_next = ST_IDLE;
      ST_OUT: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) out_valid <= 1'b0;
    if (rst) begin
      out_valid <= 1'b0;
      dram_address_reg <= '0;
      xfer_len <= '0;
      control_bit <= 1'b0;
      dac_rate_reg <= DRATE_RST;
      bit_rate_reg <= 4'hF;
      active_flag <= 1'b0;
      queued_flag <= 1'b0;
      queued_address <= '0;
      queued_length <= '0;
      bytes_left <= '0;
      fetch_cursor <= '0;
      cycle_accumulator <= '0;
      frame_period <= PERIOD_RST;
      pend_start <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (pend_start && !out_valid) begin
          pend_start <= 1'b0;
        end else if (in_valid && in_ready) begin
          read_data <= '0; fetch_valid <= 1'b0; fetch_address <= '0;
          irq_raise <= 1'b0; irq_clear <= 1'b0; job_dropped <= 1'b0; last <= 1'b1;
          cyc <= tick_cycles;
          fetched <= '0;
          if (command == CMD_READ) begin
            out_valid <= 1'b1;
            case (reg_offset & 5'h1C)
              REG_ADDR:   read_data <= {8'd0, dram_address_reg};
              REG_LEN:    read_data <= {14'd0, xfer_len};
              REG_CTRL:   read_data <= {31'd0, control_bit};
              REG_STATUS: read_data <= {queued_flag, active_flag, 30'd0};
              REG_DRATE:  read_data <= {18'd0, dac_rate_reg};
              REG_BRATE:  read_data <= {28'd0, bit_rate_reg};
              default:    read_data <= '0;
            endcase
          end else if (command == CMD_WRITE) begin
            out_valid <= 1'b1;
            case (reg_offset & 5'h1C)
              REG_ADDR: dram_address_reg <= {write_data[23:3], 3'd0};
              REG_LEN: begin
                xfer_len <= {write_data[17:3], 3'd0};
                if (write_data[17:3] != '0) begin
                  if (!active_flag) begin
                    active_flag <= 1'b1;
                    bytes_left <= {write_data[17:3], 3'd0};
                    fetch_cursor <= {8'd0, dram_address_reg};
                    cycle_accumulator <= '0;
                    pend_start <= 1'b1;
                  end else if (!queued_flag) begin
                    queued_flag <= 1'b1;
                    queued_address <= dram_address_reg;
                    queued_length <= {write_data[17:3], 3'd0};
                  end else begin
                    job_dropped <= 1'b1;
                  end
                end
              end
              REG_CTRL:   control_bit <= write_data[0];
              REG_STATUS: irq_clear <= 1'b1;
              REG_DRATE: begin
                dac_rate_reg <= write_data[13:0];
                pend_start <= 1'b1;
              end
              REG_BRATE:  bit_rate_reg <= write_data[3:0];
              default: ;
            endcase
          end else if (!(command == CMD_TICK && active_flag && bytes_left != 18'd0)) begin
            out_valid <= 1'b1;
          end
        end
        ST_DIV1: ;
        ST_DIV2: if (ddone) frame_period <= (dq[15:0] == 16'd0) ? 16'd1 : dq[15:0];
        ST_TICK: cycle_accumulator <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
        ST_FETCH: if (!out_valid || out_ready) begin
          if (can_fetch) begin
            out_valid <= 1'b1;
            fetch_valid <= 1'b1;
            fetch_address <= fetch_cursor;
            // last frame of the tick unless more follow or the job ends
            last <= (left_dec >= 18'd4) && !fetch_more;
            cycle_accumulator <= acc_dec;
            fetch_cursor <= fetch_cursor + 32'd4;
            bytes_left <= left_dec;
            xfer_len <= {left_dec[17:3], 3'd0};
            fetched <= fetched + 6'd1;
          end else if (bytes_left >= 18'd4 && fetched == 6'd0) begin
            out_valid <= 1'b1;
            fetch_valid <= 1'b0;
            fetch_address <= '0;
            last <= 1'b1;
          end
        end
        ST_IRQ: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          fetch_valid <= 1'b0; fetch_address <= '0;
          irq_raise <= 1'b1; last <= 1'b1;
          active_flag <= 1'b0;
          bytes_left <= '0;
          xfer_len <= '0;
          if (queued_flag) begin
            queued_flag <= 1'b0;
            queued_address <= '0;
            queued_length <= '0;
            active_flag <= 1'b1;
            bytes_left <= queued_length;
            xfer_len <= queued_length;
            fetch_cursor <= {8'd0, queued_address};
            cycle_accumulator <= '0;
            pend_start <= 1'b1;
          end
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end
endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  import adi_pkg::*;

  typedef struct {
    logic [31:0] rd;
    logic        fv;
    logic [31:0] fa;
    logic        ir;
    logic        ic;
    logic        jd;
    logic        lst;
  } dma_result_t;

  class dma_scoreboard;
    dma_result_t pending_q[$];
    int errors;
    logic [31:0] addr_r, len_r, ctrl_r, drate_r, brate_r;
    logic        active, queued;
    logic [31:0] q_addr, q_len, left, cursor, accum, period;

    function new();
      errors = 0;
      addr_r = 0; len_r = 0; ctrl_r = 0; brate_r = 4'hF;
      drate_r = (DAC_CLOCK_HZ_DEF / DEFAULT_RATE_DEF - 1) & 32'h3FFF;
      active = 0; queued = 0; q_addr = 0; q_len = 0;
      left = 0; cursor = 0; accum = 0;
      update_period();
    endfunction

    function void update_period();
      int unsigned d, r, p;
      d = drate_r & 32'h3FFF;
      if (d == 0) r = DEFAULT_RATE_DEF;
      else begin
        r = DAC_CLOCK_HZ_DEF / (d + 1);
        if (r < RATE_MIN) r = RATE_MIN;
        if (r > RATE_MAX) r = RATE_MAX;
      end
      p = CPU_CLOCK_HZ_DEF / r;
      if (p == 0) p = 1;
      period = p & 32'hFFFF;
      if (period == 0) period = 1;
    endfunction

    function void begin_job(logic [31:0] a, logic [31:0] l);
      active = 1; left = l; cursor = a; len_r = l; accum = 0;
      update_period();
    endfunction

    function void push(logic [31:0] rd, logic fv, logic [31:0] fa,
                       logic ir, logic ic, logic jd);
      dma_result_t e;
      e.rd = rd; e.fv = fv; e.fa = fa; e.ir = ir; e.ic = ic; e.jd = jd; e.lst = 0;
      pending_q.push_back(e);
    endfunction

    function void note_request(logic [1:0] cmd, logic [4:0] off_raw,
                               logic [31:0] val, logic [14:0] cyc);
      logic [4:0] off;
      logic [31:0] rd;
      logic clr, drop;
      int n;
      off = off_raw & 5'h1C;
      n = pending_q.size();
      if (cmd == CMD_READ) begin
        rd = 0;
        case (off)
          REG_ADDR:   rd = addr_r & 32'h00FF_FFF8;
          REG_LEN:    rd = len_r & 32'h0003_FFF8;
          REG_CTRL:   rd = ctrl_r & 1;
          REG_STATUS: rd = {queued, active, 30'd0};
          REG_DRATE:  rd = drate_r & 32'h3FFF;
          REG_BRATE:  rd = brate_r & 32'hF;
          default:    rd = 0;
        endcase
        push(rd, 0, 0, 0, 0, 0);
      end else if (cmd == CMD_WRITE) begin
        clr = 0; drop = 0;
        case (off)
          REG_ADDR: addr_r = val & 32'h00FF_FFF8;
          REG_LEN: begin
            len_r = val & 32'h0003_FFF8;
            if (len_r != 0) begin
              if (!active) begin_job(addr_r, len_r);
              else if (!queued) begin
                queued = 1; q_addr = addr_r; q_len = len_r;
              end else drop = 1;
            end
          end
          REG_CTRL:   ctrl_r = val & 1;
          REG_STATUS: clr = 1;
          REG_DRATE: begin
            drate_r = val & 32'h3FFF;
            update_period();
          end
          REG_BRATE:  brate_r = val & 32'hF;
          default: ;
        endcase
        push(0, 0, 0, 0, clr, drop);
      end else if (cmd == CMD_TICK) begin
        if (active && left != 0) begin
          int fetched;
          fetched = 0;
          if (accum > 32'hFFFF_FFFF - cyc) accum = 32'hFFFF_FFFF;
          else accum = accum + cyc;
          while (fetched < MAX_FETCH && accum >= period && left >= 4) begin
            accum = accum - period;
            push(0, 1, cursor, 0, 0, 0);
            fetched++;
            cursor = cursor + 4;
            left = left - 4;
            len_r = left & 32'h0003_FFF8;
          end
          if (left < 4) begin
            active = 0; left = 0; len_r = 0;
            push(0, 0, 0, 1, 0, 0);
            if (queued) begin
              queued = 0;
              begin_job(q_addr, q_len);
              q_addr = 0; q_len = 0;
            end
          end
        end
        if (pending_q.size() == n) push(0, 0, 0, 0, 0, 0);
      end else begin
        push(0, 0, 0, 0, 0, 0);
      end
      pending_q[pending_q.size()-1].lst = 1;
    endfunction

    function void check_result(dma_result_t a);
      dma_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result rd=%h fv=%b fa=%h", a.rd, a.fv, a.fa);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (a.rd !== e.rd) begin
        $error("read_data exp %h got %h", e.rd, a.rd); errors++;
      end
      if (a.fv !== e.fv) begin
        $error("fetch_valid exp %b got %b", e.fv, a.fv); errors++;
      end
      if (a.fa !== e.fa) begin
        $error("fetch_address exp %h got %h", e.fa, a.fa); errors++;
      end
      if (a.ir !== e.ir) begin
        $error("irq_raise exp %b got %b", e.ir, a.ir); errors++;
      end
      if (a.ic !== e.ic) begin
        $error("irq_clear exp %b got %b", e.ic, a.ic); errors++;
      end
      if (a.jd !== e.jd) begin
        $error("job_dropped exp %b got %b", e.jd, a.jd); errors++;
      end
      if (a.lst !== e.lst) begin
        $error("last exp %b got %b", e.lst, a.lst); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  command = 0;
  logic [4:0]  reg_offset = 0;
  logic [31:0] write_data = 0;
  logic [14:0] tick_cycles = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] read_data;
  logic        fetch_valid;
  logic [31:0] fetch_address;
  logic        irq_raise;
  logic        irq_clear;
  logic        job_dropped;
  logic        last;

  dma_scoreboard sb = new();
  bit calm = 0;

  audio_dma_interface_with_rate_pacing uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .reg_offset(reg_offset),
    .write_data(write_data), .tick_cycles(tick_cycles),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_data(read_data), .fetch_valid(fetch_valid),
    .fetch_address(fetch_address), .irq_raise(irq_raise),
    .irq_clear(irq_clear), .job_dropped(job_dropped), .last(last)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    dma_result_t r;
    if (!rst && out_valid && out_ready) begin
      r.rd = read_data; r.fv = fetch_valid; r.fa = fetch_address;
      r.ir = irq_raise; r.ic = irq_clear; r.jd = job_dropped; r.lst = last;
      sb.check_result(r);
    end
    out_ready <= rst ? 1'b0 : (calm || $urandom_range(99) >= 25);
  end

  task automatic send(logic [1:0] cmd, logic [4:0] off, logic [31:0] val,
                      logic [14:0] cyc);
    if (!calm && $urandom_range(99) < 25) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    command <= cmd;
    reg_offset <= off;
    write_data <= val;
    tick_cycles <= cyc;
    do @(posedge clk); while (!in_ready);
    sb.note_request(cmd, off, val, cyc);
  endtask

  task automatic wr(logic [4:0] off, logic [31:0] val);
    send(CMD_WRITE, off, val, 15'($urandom));
  endtask

  task automatic send_random();
    int r;
    logic [31:0] v;
    r = $urandom_range(99);
    v = $urandom;
    if (r < 50)
      send(CMD_TICK, 5'($urandom), $urandom,
           15'(($urandom_range(3) == 0) ? $urandom_range(0, 32767)
                                         : $urandom_range(0, 8000)));
    else if (r < 62)
      wr(5'(REG_LEN | ($urandom & 3)), (v & 32'hFFFC_0007) | ($urandom_range(1, 32) << 3));
    else if (r < 70) wr(REG_ADDR, v);
    else if (r < 76) begin
      case ($urandom_range(3))
        0: v = v & 32'hFFFF_C000;
        1: v = (v & 32'hFFFF_C000) | $urandom_range(1, 600);
        2: v = v | 32'h3FFF;
        default: ;
      endcase
      wr(REG_DRATE, v);
    end else if (r < 82) send(CMD_READ, 5'($urandom), $urandom, 15'($urandom));
    else if (r < 86) wr(REG_STATUS, v);
    else if (r < 90) wr($urandom_range(1) ? REG_CTRL : REG_BRATE, v);
    else if (r < 93) send(CMD_UNUSED, 5'($urandom), $urandom, 15'($urandom));
    else begin
      logic [1:0] c;
      logic [4:0] o;
      c = 2'($urandom);
      o = 5'($urandom);
      if ((o & 5'h1C) == REG_LEN) v = v & 32'hFFFC_03FF;
      send(c, o, v, 15'($urandom));
    end
  endtask

  initial begin
    int guard;
    repeat (10) @(posedge clk);
    rst <= 0;
    for (int i = 0; i < 8; i++) send(CMD_READ, 5'(i * 4), $urandom, 15'($urandom));
    send(CMD_READ, 5'h1F, 0, 0);
    wr(REG_ADDR, 32'hFFFF_FFFF);
    send(CMD_READ, REG_ADDR, 0, 0);
    wr(REG_CTRL, 32'hFFFF_FFFF);
    wr(REG_BRATE, 32'hFFFF_FFFF);
    wr(REG_LEN, 32'h0000_0007);
    send(CMD_UNUSED, 5'h1F, 32'hFFFF_FFFF, 15'h7FFF);
    send(CMD_TICK, 0, 0, 15'h7FFF);
    wr(REG_ADDR, 32'h0000_1000);
    wr(REG_LEN, 32'd16);
    wr(REG_LEN, 32'd32);
    wr(REG_LEN, 32'd8);
    send(CMD_READ, REG_STATUS, 0, 0);
    send(CMD_TICK, 0, 0, 15'h7FFF);
    send(CMD_TICK, 0, 0, 15'h7FFF);
    wr(REG_STATUS, 0);
    wr(REG_DRATE, 0);
    wr(REG_DRATE, 32'h3FFF);
    wr(REG_DRATE, 32'd1);
    send(CMD_TICK, 0, 0, 0);
    for (int i = 0; i < 330; i++) begin
      calm = (i >= 150 && i < 210);
      send_random();
    end
    in_valid <= 0;
    calm = 0;
    guard = 0;
    while (sb.pending_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #36000000;
    $display("tb: failure");
    $finish;
  end
endmodule

/* audio_dma_interface_with_rate_pacing.f */
design/adi_pkg.sv
design/adi_div.sv
design/audio_dma_interface_with_rate_pacing.sv
tb/sv/tb_top.sv
